>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising edge, disabled while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

>>> design/sbcc_pkg.sv
package sbcc_pkg;

  localparam int unsigned COORD_W    = 10;
  localparam int unsigned DIM_W      = 7;
  localparam int unsigned COLOR_W    = 16;
  localparam int unsigned COUNT_W    = 6;
  localparam int unsigned SX_W       = 11;
  localparam int unsigned X_W        = 9;
  localparam int unsigned Y_W        = 8;
  localparam int unsigned OFFSET_W   = 18;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 56;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPRITE_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPRITE_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSP_COLOR  = 3'd4;

  typedef struct packed {
    logic [COORD_W-1:0] anchor_x;
    logic [COORD_W-1:0] anchor_y;
    logic [DIM_W-1:0]   sprite_width;
    logic [DIM_W-1:0]   sprite_height;
    logic [COLOR_W-1:0] transparent_color;
  } sbcc_cfg_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [COUNT_W-1:0] col;
    logic [COUNT_W-1:0] row;
  } sbcc_pix_t;

  // Packed so that write_x lands in the lowest bits.
  typedef struct packed {
    logic [COLOR_W-1:0]  color;
    logic [OFFSET_W-1:0] offset;
    logic [Y_W-1:0]      y;
    logic [X_W-1:0]      x;
  } sbcc_wr_t;

endpackage

>>> design/sprite_blit_colorkey_clip.sv
// Channel  | Direction | Contents (low bit up)
// in_*     | slave     | tdata[15:0] pixel_color
// out_*    | master    | tdata: write_x, write_y, byte_offset, write_color, zero pad
// cfg_*    | write     | cfg_index selects register, cfg_wdata carries value
//
// One word per cycle on the input while in_tready is high; a result passes
// through the input register and then the result register.
// Synchronous active-low reset clears counters and valid flags and resets config registers.
// A stalled result holds; the input register empties whenever its word is
// dropped or the result register is free or being taken.
`include "assert_macros.svh"

module sprite_blit_colorkey_clip #(
  parameter int unsigned SCREEN_WIDTH   = 320,
  parameter int unsigned SCREEN_HEIGHT  = 240,
  parameter int unsigned MAX_SPRITE_DIM = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sbcc_pkg::IN_DATA_W-1:0]    in_tdata,   // [15:0] pixel_color
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [8:0] write_x, [16:9] write_y, [34:17] byte_offset, [50:35] write_color
  output logic [sbcc_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                              cfg_we,
  input  logic [sbcc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sbcc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int unsigned WR_W = $bits(sbcc_pkg::sbcc_wr_t);

  sbcc_pkg::sbcc_cfg_t          cfg;
  logic [sbcc_pkg::COUNT_W-1:0] col, row;
  logic                         in_acc;
  logic                         hit;
  logic                         out_free;
  logic                         s1_go;
  sbcc_pkg::sbcc_wr_t           wr;

  logic                s1_valid_r, s1_valid_nxt;
  sbcc_pkg::sbcc_pix_t s1_pix_r, s1_pix_nxt;
  logic                out_valid_r, out_valid_nxt;
  sbcc_pkg::sbcc_wr_t  out_wr_r, out_wr_nxt;

  sbcc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sbcc_pos_counter #(
    .MAX_SPRITE_DIM (MAX_SPRITE_DIM)
  ) u_pos (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (in_acc),
    .sprite_width  (cfg.sprite_width),
    .sprite_height (cfg.sprite_height),
    .col           (col),
    .row           (row)
  );

  sbcc_clip_key #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_clip (
    .pix (s1_pix_r),
    .cfg (cfg),
    .hit (hit),
    .wr  (wr)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign s1_go     = s1_valid_r && (!hit || out_free);
  assign in_tready = !s1_valid_r || s1_go;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_pix_nxt   = s1_pix_r;
    if (in_acc) begin
      s1_valid_nxt     = 1'b1;
      s1_pix_nxt.color = in_tdata;
      s1_pix_nxt.col   = col;
      s1_pix_nxt.row   = row;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_wr_nxt    = out_wr_r;
    if (s1_go && hit) begin
      out_valid_nxt = 1'b1;
      out_wr_nxt    = wr;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_pix_r <= s1_pix_nxt;
    out_wr_r <= out_wr_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(sbcc_pkg::OUT_DATA_W - WR_W)'(0), out_wr_r};

  `ASSERT_CLK(a_accept_fills_stage, clk, rst_n, in_acc |=> s1_valid_r)
  `ASSERT_CLK(a_offset_matches_xy, clk, rst_n,
              out_valid_r |-> out_wr_r.offset == {out_wr_r.y, out_wr_r.x, 1'b0})
  `ASSERT_CLK(a_hit_loads_result, clk, rst_n, s1_go && hit |=> out_valid_r)

endmodule

>>> design/sbcc_cfg_regs.sv
module sbcc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sbcc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sbcc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output sbcc_pkg::sbcc_cfg_t              cfg
);

  sbcc_pkg::sbcc_cfg_t cfg_r;
  sbcc_pkg::sbcc_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        sbcc_pkg::REG_ANCHOR_X:      cfg_nxt.anchor_x = cfg_wdata[sbcc_pkg::COORD_W-1:0];
        sbcc_pkg::REG_ANCHOR_Y:      cfg_nxt.anchor_y = cfg_wdata[sbcc_pkg::COORD_W-1:0];
        sbcc_pkg::REG_SPRITE_WIDTH:  cfg_nxt.sprite_width = cfg_wdata[sbcc_pkg::DIM_W-1:0];
        sbcc_pkg::REG_SPRITE_HEIGHT: cfg_nxt.sprite_height = cfg_wdata[sbcc_pkg::DIM_W-1:0];
        sbcc_pkg::REG_TRANSP_COLOR:  cfg_nxt.transparent_color = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.anchor_x          <= '0;
      cfg_r.anchor_y          <= '0;
      cfg_r.sprite_width      <= sbcc_pkg::DIM_W'(1);
      cfg_r.sprite_height     <= sbcc_pkg::DIM_W'(1);
      cfg_r.transparent_color <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> design/sbcc_pos_counter.sv
`include "assert_macros.svh"

module sbcc_pos_counter #(
  parameter int unsigned MAX_SPRITE_DIM = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic [sbcc_pkg::DIM_W-1:0]     sprite_width,
  input  logic [sbcc_pkg::DIM_W-1:0]     sprite_height,
  output logic [sbcc_pkg::COUNT_W-1:0]   col,
  output logic [sbcc_pkg::COUNT_W-1:0]   row
);

  localparam logic [sbcc_pkg::DIM_W-1:0] MAX_DIM = sbcc_pkg::DIM_W'(MAX_SPRITE_DIM);

  function automatic logic [sbcc_pkg::DIM_W-1:0] eff_dim(input logic [sbcc_pkg::DIM_W-1:0] d);
    logic [sbcc_pkg::DIM_W-1:0] r;
    if (d == '0) begin
      r = sbcc_pkg::DIM_W'(1);
    end else if (d > MAX_DIM) begin
      r = MAX_DIM;
    end else begin
      r = d;
    end
    return r;
  endfunction

  logic [sbcc_pkg::COUNT_W-1:0] col_r, col_nxt;
  logic [sbcc_pkg::COUNT_W-1:0] row_r, row_nxt;
  logic [sbcc_pkg::DIM_W-1:0]   col_inc, row_inc;
  logic                         col_wrap, row_wrap;

  assign col_inc  = {1'b0, col_r} + sbcc_pkg::DIM_W'(1);
  assign row_inc  = {1'b0, row_r} + sbcc_pkg::DIM_W'(1);
  assign col_wrap = col_inc >= eff_dim(sprite_width);
  assign row_wrap = row_inc >= eff_dim(sprite_height);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (adv) begin
      if (col_wrap) begin
        col_nxt = '0;
        row_nxt = row_wrap ? '0 : row_inc[sbcc_pkg::COUNT_W-1:0];
      end else begin
        col_nxt = col_inc[sbcc_pkg::COUNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign col = col_r;
  assign row = row_r;

  `ASSERT_CLK(a_col_wrap_clears, clk, rst_n, adv && col_wrap |=> col_r == '0)
  `ASSERT_CLK(a_row_holds_mid_row, clk, rst_n, adv && !col_wrap |=> row_r == $past(row_r))

endmodule

>>> design/sbcc_clip_key.sv
module sbcc_clip_key #(
  parameter int unsigned SCREEN_WIDTH  = 320,
  parameter int unsigned SCREEN_HEIGHT = 240
) (
  input  sbcc_pkg::sbcc_pix_t pix,
  input  sbcc_pkg::sbcc_cfg_t cfg,
  output logic                hit,
  output sbcc_pkg::sbcc_wr_t  wr
);

  localparam logic [sbcc_pkg::SX_W-1:0] SCR_W = sbcc_pkg::SX_W'(SCREEN_WIDTH);
  localparam logic [sbcc_pkg::SX_W-1:0] SCR_H = sbcc_pkg::SX_W'(SCREEN_HEIGHT);

  logic [sbcc_pkg::SX_W-1:0] sx, sy;

  assign sx = {1'b0, cfg.anchor_x} + sbcc_pkg::SX_W'(pix.col);
  assign sy = {1'b0, cfg.anchor_y} + sbcc_pkg::SX_W'(pix.row);

  assign hit = (sx < SCR_W) && (sy < SCR_H) && (pix.color != cfg.transparent_color);

  assign wr.x      = sx[sbcc_pkg::X_W-1:0];
  assign wr.y      = sy[sbcc_pkg::Y_W-1:0];
  assign wr.offset = {sy[sbcc_pkg::Y_W-1:0], sx[sbcc_pkg::X_W-1:0], 1'b0};
  assign wr.color  = pix.color;

endmodule
